// ----- src/mep_pkg.sv -----
// Shared types, constants and helper functions for the escape-time pixel core.
// Used by the channel interfaces, the controller, the datapath and the top level.
package mep_pkg;

  // Fixed-point format and coordinate range.
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 28;

  // Field widths of the channels and the configuration port.
  localparam int PIX_W    = 12;
  localparam int GRAY_W   = 8;
  localparam int ITER_W   = 16;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W   = 31;
  localparam int MOD_W    = 7;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t REG_ORIGIN_RE = 2'd0;
  localparam cfg_idx_t REG_ORIGIN_IM = 2'd1;
  localparam cfg_idx_t REG_STEP      = 2'd2;
  localparam cfg_idx_t REG_MAX_ITER  = 2'd3;

  // Reset values: origin at (-250/150, -150/150), one pixel is 1/150.
  localparam logic signed [CFG_W-1:0] ORE_RESET =
    CFG_W'(-(((longint'(250) <<< FRAC_BITS) + 75) / 150));
  localparam logic signed [CFG_W-1:0] OIM_RESET =
    CFG_W'(-((longint'(150) <<< FRAC_BITS) / 150));
  localparam logic [STEP_W-1:0] STEP_RESET =
    STEP_W'(((longint'(1) <<< FRAC_BITS) + 75) / 150);
  localparam logic [ITER_W-1:0] LIMIT_RESET = ITER_W'(1000);

  // Escape bound |z|^2 >= 4 in the double-precision product format.
  localparam logic [63:0] ESCAPE_SQ = 64'(1) << (2 * FRAC_BITS + 2);

  // Gray scale: ((m * 255) / 100) for m below 100, done by a reciprocal.
  localparam int GRAY_PERIOD = 100;
  localparam int GRAY_SHIFT  = 22;
  localparam int GRAY_RECIP  = 255 * (((1 << GRAY_SHIFT) / GRAY_PERIOD) + 1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // latch the pixel of an accepted beat
    logic init;    // form c and seed z = c
    logic mult;    // register the three products of z
    logic update;  // take z*z + c and count one iteration
    logic finish;  // load the result register
  } mep_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic at_limit;  // iteration count equals the limit
    logic escape;    // registered |z|^2 has reached the bound
  } mep_sts_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [CFG_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[CFG_W-1:0];
  endfunction

  // Gray level of a count already reduced modulo the period.
  function automatic logic [GRAY_W-1:0] gray_of(input logic [MOD_W-1:0] m);
    logic [31:0] p;
    p = 32'(m) * 32'(GRAY_RECIP);
    return p[GRAY_SHIFT +: GRAY_W];
  endfunction

endpackage

// ----- src/mep_if.sv -----
// Valid/ready channel interfaces for pixel beats and result beats.
// Depends on mep_pkg for the field widths.
interface mep_in_if;
  import mep_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_x;
  logic [PIX_W-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface mep_out_if;
  import mep_pkg::*;
  logic              valid;
  logic              ready;
  logic [GRAY_W-1:0] gray;
  logic [ITER_W-1:0] iterations;
  logic              inside_res;

  modport source (output valid, output gray, output iterations, output inside_res,
                  input ready);
  modport sink   (input valid, input gray, input iterations, input inside_res,
                  output ready);
endinterface

// ----- src/mep_ctrl.sv -----
// Controller state machine of the escape-time core: sequences one pixel
// through seed, multiply and update steps. Depends on mep_pkg.
module mep_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  mep_pkg::mep_sts_t sts_i,
  output mep_pkg::mep_cmd_t cmd_o
);
  import mep_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_INIT = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt     = state_r;
    cmd_o         = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_nxt  = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        state_nxt  = ST_MUL;
      end
      ST_MUL: begin
        if (sts_i.at_limit) begin
          state_nxt = ST_DONE;
        end else begin
          cmd_o.mult = 1'b1;
          state_nxt  = ST_UPD;
        end
      end
      ST_UPD: begin
        if (sts_i.escape) begin
          state_nxt = ST_DONE;
        end else begin
          cmd_o.update = 1'b1;
          state_nxt    = ST_MUL;
        end
      end
      ST_DONE: begin
        // The result register takes the beat once it is empty or being drained.
        if (!out_valid_r || out_ready) begin
          cmd_o.finish  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // A loaded result is presented on the next cycle.
  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.finish |=> out_valid_r)
    else $error("result register loaded but output valid not raised");

  // An escape ends the iteration loop.
  a_escape_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD && sts_i.escape) |=> (state_r == ST_DONE))
    else $error("escape did not end the iteration loop");

  // Reaching the limit ends the iteration loop.
  a_limit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL && sts_i.at_limit) |=> (state_r == ST_DONE))
    else $error("iteration limit did not end the loop");

  // Output valid rises only out of the completion state.
  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("output valid raised outside completion");

endmodule

// ----- src/mep_dp.sv -----
// Datapath of the escape-time core: configuration registers, point seeding,
// the z*z + c iteration registers and the result register. Depends on mep_pkg.
module mep_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  mep_pkg::cfg_idx_t             cfg_index,
  input  logic [mep_pkg::CFG_W-1:0]     cfg_data,
  input  logic [mep_pkg::PIX_W-1:0]     pixel_x,
  input  logic [mep_pkg::PIX_W-1:0]     pixel_y,
  input  mep_pkg::mep_cmd_t             cmd_i,
  output mep_pkg::mep_sts_t             sts_o,
  output logic [mep_pkg::GRAY_W-1:0]    gray,
  output logic [mep_pkg::ITER_W-1:0]    iterations,
  output logic                          inside_res
);
  import mep_pkg::*;

  localparam int PROD_W = COORD_BITS + STEP_W;

  // Configuration registers.
  logic signed [CFG_W-1:0]  origin_re_r, origin_im_r;
  logic        [STEP_W-1:0] step_r;
  logic        [ITER_W-1:0] max_iter_r;

  // Working registers.
  logic [COORD_BITS-1:0]    px_r, py_r;
  logic signed [CFG_W-1:0]  cr_r, ci_r, zr_r, zi_r;
  logic signed [63:0]       rr_r, ii_r, ri_r;
  logic [ITER_W-1:0]        n_r;
  logic [MOD_W-1:0]         nmod_r;

  // Result register.
  logic [GRAY_W-1:0]        gray_r;
  logic [ITER_W-1:0]        iter_r;
  logic                     inside_r;

  logic [PROD_W-1:0]        pxs, pys;
  logic signed [CFG_W-1:0]  cr_nxt, ci_nxt, zr_nxt, zi_nxt;
  logic [63:0]              mag_sum;
  logic                     at_limit;

  // Configuration writes; indexes outside the list do not occur with a 2-bit index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_re_r <= ORE_RESET;
      origin_im_r <= OIM_RESET;
      step_r      <= STEP_RESET;
      max_iter_r  <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_RE: origin_re_r <= cfg_data;
        REG_ORIGIN_IM: origin_im_r <= cfg_data;
        REG_STEP:      step_r      <= cfg_data[STEP_W-1:0];
        REG_MAX_ITER:  max_iter_r  <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // Point c = origin + pixel * step, clamped to the register range.
  always_comb begin
    pxs    = PROD_W'(px_r) * PROD_W'(step_r);
    pys    = PROD_W'(py_r) * PROD_W'(step_r);
    cr_nxt = sat32(64'(origin_re_r) + signed'(64'(pxs)));
    ci_nxt = sat32(64'(origin_im_r) + signed'(64'(pys)));
  end

  // Next iterate from the registered products; floor shift back to FRAC_BITS.
  // The cross term is doubled by shifting one place less.
  always_comb begin
    zr_nxt = sat32(((rr_r - ii_r) >>> FRAC_BITS) + 64'(cr_r));
    zi_nxt = sat32((ri_r >>> (FRAC_BITS - 1)) + 64'(ci_r));
  end

  // Escape test and limit test.
  assign mag_sum        = unsigned'(rr_r) + unsigned'(ii_r);
  assign at_limit       = (n_r == max_iter_r);
  assign sts_o.escape   = (mag_sum >= ESCAPE_SQ);
  assign sts_o.at_limit = at_limit;

  // Pixel latch, seeding, products and iteration update.
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      px_r <= COORD_BITS'(pixel_x);
      py_r <= COORD_BITS'(pixel_y);
    end
    if (cmd_i.init) begin
      cr_r   <= cr_nxt;
      ci_r   <= ci_nxt;
      zr_r   <= cr_nxt;
      zi_r   <= ci_nxt;
      n_r    <= '0;
      nmod_r <= '0;
    end
    if (cmd_i.mult) begin
      rr_r <= zr_r * zr_r;
      ii_r <= zi_r * zi_r;
      ri_r <= zr_r * zi_r;
    end
    if (cmd_i.update) begin
      zr_r <= zr_nxt;
      zi_r <= zi_nxt;
      n_r  <= n_r + 1'b1;
      // Count modulo the gray period alongside the iteration count.
      if (nmod_r == MOD_W'(GRAY_PERIOD - 1)) begin
        nmod_r <= '0;
      end else begin
        nmod_r <= nmod_r + 1'b1;
      end
    end
  end

  // Result register, loaded when the loop has ended.
  always_ff @(posedge clk) begin
    if (cmd_i.finish) begin
      iter_r   <= n_r;
      inside_r <= at_limit;
      gray_r   <= at_limit ? '0 : gray_of(nmod_r);
    end
  end

  assign gray       = gray_r;
  assign iterations = iter_r;
  assign inside_res = inside_r;

endmodule

// ----- src/mandelbrot_escape_pixel_core.sv -----
// Escape-time pixel core: maps a pixel to c = origin + pixel * step in Q4.28 and counts
// iterations of z = z*z + c until |z|^2 reaches 4 or the count reaches max_iter. One
// pixel is in work at a time; an iteration registers three 32x32 products, then makes
// the escape test and the update. The next pixel is accepted while the previous result
// still waits in the output register. Depends on mep_pkg, the channel interfaces,
// mep_ctrl and mep_dp.
module mandelbrot_escape_pixel_core (
  input  logic                      clk,
  input  logic                      rst_n,
  mep_in_if.sink                    in_ch,
  mep_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  mep_pkg::cfg_idx_t         cfg_index,
  input  logic [mep_pkg::CFG_W-1:0] cfg_data
);
  import mep_pkg::*;

  mep_cmd_t cmd;
  mep_sts_t sts;

  // Sequencer.
  mep_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Arithmetic and registers.
  mep_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixel_x    (in_ch.pixel_x),
    .pixel_y    (in_ch.pixel_y),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .gray       (out_ch.gray),
    .iterations (out_ch.iterations),
    .inside_res (out_ch.inside_res)
  );

endmodule

// ----- dv/tb_mandelbrot_escape_pixel_core.sv -----
// Self-checking testbench for the escape-time pixel core: pixel beats in, result beats out.
// Results are predicted here in 64-bit fixed point and checked beat by beat, in order.
// Depends on mep_pkg, the channel interfaces in mep_if.sv and mandelbrot_escape_pixel_core.
module tb_mandelbrot_escape_pixel_core;
  timeunit 1ns;
  timeprecision 1ps;
  import mep_pkg::*;

  localparam int          GRAY_TOP       = 255;
  localparam int          COORD_MASK     = (1 << COORD_BITS) - 1;
  localparam int unsigned WATCHDOG_LIMIT = 400000;
  localparam int          DRAIN_CYCLES   = 16;
  localparam int          RANDOM_PHASES  = 8;
  localparam int          PHASE_PIXELS   = 75;
  localparam int          MAX_REPORTS    = 10;

  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
  } pixel_t;

  typedef struct packed {
    logic [GRAY_W-1:0] gray;
    logic [ITER_W-1:0] iterations;
    logic              in_set;
  } escape_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  cfg_idx_t          cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  mep_in_if  in_ch ();
  mep_out_if out_ch ();

  mandelbrot_escape_pixel_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Our own copy of the plane window and the iteration limit.
  logic signed [CFG_W-1:0]  re_origin;
  logic signed [CFG_W-1:0]  im_origin;
  logic [STEP_W-1:0]        plane_step;
  logic [ITER_W-1:0]        iter_limit;

  pixel_t      pending_pixels[$];
  escape_t     pending_escapes[$];
  int unsigned pixels_issued;
  int unsigned pixels_taken;
  int unsigned bad_beats;
  int unsigned quiet_cycles;
  int unsigned in_gap;
  int unsigned ready_left;
  logic        in_taken;
  logic        send_idle;
  logic        recv_idle;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clamp to the signed 32-bit range of a Q4.28 register.
  function automatic longint clamp_q428(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Escape-time count of one pixel under the current window and limit.
  function automatic escape_t escape_time(input pixel_t p);
    longint      cr;
    longint      ci;
    longint      zr;
    longint      zi;
    longint      rr;
    longint      ii;
    longint      nr;
    longint      ni;
    logic [63:0] mag;
    int unsigned n;
    escape_t     r;
    cr = clamp_q428(longint'(re_origin) +
                    (longint'(p.x) & COORD_MASK) * longint'(plane_step));
    ci = clamp_q428(longint'(im_origin) +
                    (longint'(p.y) & COORD_MASK) * longint'(plane_step));
    zr = cr;
    zi = ci;
    n  = 0;
    while (n < iter_limit) begin
      rr  = zr * zr;
      ii  = zi * zi;
      mag = rr + ii;
      if (mag >= ESCAPE_SQ) begin
        break;
      end
      // Arithmetic shift rounds toward minus infinity, as the datapath does.
      nr = ((rr - ii) >>> FRAC_BITS) + cr;
      ni = ((2 * zr * zi) >>> FRAC_BITS) + ci;
      zr = clamp_q428(nr);
      zi = clamp_q428(ni);
      n++;
    end
    r.in_set     = (n == iter_limit);
    r.iterations = n[ITER_W-1:0];
    r.gray       = r.in_set ? '0 : GRAY_W'(((n % GRAY_PERIOD) * GRAY_TOP) / GRAY_PERIOD);
    return r;
  endfunction

  // Gap length: mostly short, now and then a long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic void note_failure(input string msg);
    bad_beats++;
    if (bad_beats <= MAX_REPORTS) begin
      $display("%0t ns: %s", $realtime, msg);
    end
  endfunction

  // Pixel driver: holds a beat until it is taken; when gaps are enabled, it sometimes inserts a random gap.
  always @(negedge clk) begin : feed_pixels
    pixel_t nxt;
    if (rst_n) begin
      if (!in_ch.valid || in_taken) begin
        if (in_gap != 0) begin
          in_gap      <= in_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          nxt = pending_pixels.pop_front();
          in_ch.pixel_x <= nxt.x;
          in_ch.pixel_y <= nxt.y;
          in_ch.valid   <= 1'b1;
          in_gap        <= (send_idle && $urandom_range(0, 1) == 0) ? pick_gap() : 0;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result sink: ready drops for random stretches when stalls are enabled.
  always @(negedge clk) begin : accept_results
    if (rst_n) begin
      if (ready_left != 0) begin
        ready_left <= ready_left - 1;
      end else if (recv_idle && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        ready_left   <= pick_gap();
      end else begin
        out_ch.ready <= 1'b1;
        ready_left   <= $urandom_range(0, 6);
      end
    end
  end

  // Monitor: predicts on each pixel beat, checks each result beat, and guards against hangs.
  always @(posedge clk) begin : observe
    escape_t got;
    escape_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        pending_escapes.push_back(escape_time('{x: in_ch.pixel_x, y: in_ch.pixel_y}));
        pixels_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{gray: out_ch.gray, iterations: out_ch.iterations, in_set: out_ch.inside_res};
        if (pending_escapes.size() == 0) begin
          note_failure($sformatf("result beat with no pixel pending: %s %0d %s %0d %s %0b",
                                 "gray", got.gray, "iter", got.iterations,
                                 "inside", got.in_set));
        end else begin
          want = pending_escapes.pop_front();
          if (got.gray !== want.gray || got.iterations !== want.iterations ||
              got.in_set !== want.in_set) begin
            note_failure($sformatf({"result mismatch: expected gray %0d iter %0d inside %0b,",
                                    " got gray %0d iter %0d inside %0b"},
                                   want.gray, want.iterations, want.in_set,
                                   got.gray, got.iterations, got.in_set));
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Register write; our copy keeps only the bits the register holds.
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_ORIGIN_RE: re_origin  = value;
      REG_ORIGIN_IM: im_origin  = value;
      REG_STEP:      plane_step = value[STEP_W-1:0];
      REG_MAX_ITER:  iter_limit = value[ITER_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_pixel(input int x, input int y);
    pending_pixels.push_back('{x: PIX_W'(x), y: PIX_W'(y)});
    pixels_issued++;
  endtask

  // Wait until every pixel is taken and every result has come back.
  task automatic wait_idle();
    while (pixels_taken != pixels_issued || pending_escapes.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One random window: mostly near the set, once raw register noise.
  task automatic run_random_phase(input int idx);
    logic [CFG_W-1:0] ore;
    logic [CFG_W-1:0] oim;
    logic [CFG_W-1:0] stp;
    logic [CFG_W-1:0] lim;
    if (idx == 5) begin
      ore = $urandom();
      oim = $urandom();
      stp = $urandom();
      lim = $urandom_range(1, 48) | ($urandom() & 32'hFFFF_0000);
    end else begin
      ore = 32'($urandom_range(0, 805306368)) - 32'd671088640;
      oim = 32'($urandom_range(0, 805306368)) - 32'd402653184;
      stp = $urandom_range(1024, 131072);
      lim = (idx == 3) ? $urandom_range(100, 300) : $urandom_range(1, 48);
    end
    write_reg(REG_ORIGIN_RE, ore);
    write_reg(REG_ORIGIN_IM, oim);
    write_reg(REG_STEP, stp);
    write_reg(REG_MAX_ITER, lim);
    case (idx % 4)
      0: begin send_idle = 1'b1; recv_idle = 1'b1; end
      1: begin send_idle = 1'b0; recv_idle = 1'b0; end
      2: begin send_idle = 1'b1; recv_idle = 1'b0; end
      default: begin send_idle = 1'b0; recv_idle = 1'b1; end
    endcase
    repeat (PHASE_PIXELS) queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
    wait_idle();
  endtask

  // Stimulus sequence.
  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_ORIGIN_RE;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.pixel_x = '0;
    in_ch.pixel_y = '0;
    out_ch.ready  = 1'b0;
    re_origin     = ORE_RESET;
    im_origin     = OIM_RESET;
    plane_step    = STEP_RESET;
    iter_limit    = LIMIT_RESET;
    pixels_issued = 0;
    pixels_taken  = 0;
    bad_beats     = 0;
    quiet_cycles  = 0;
    in_gap        = 0;
    ready_left    = 0;
    in_taken      = 1'b0;
    send_idle     = 1'b1;
    recv_idle     = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset window: corners, the origin point of the plane, and a point inside the set.
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(250, 150);
    queue_pixel(0, 150);
    queue_pixel(325, 150);
    queue_pixel(4095, 0);
    queue_pixel(0, 4095);
    wait_idle();

    // Extreme origins and step: c saturates high or sits at the low end of its range. Upper data bits must be dropped.
    write_reg(REG_ORIGIN_RE, 32'h7FFF_FFFF);
    write_reg(REG_ORIGIN_IM, 32'h8000_0000);
    write_reg(REG_STEP, 32'hFFFF_FFFF);
    write_reg(REG_MAX_ITER, 32'hFFFF_0007);
    queue_pixel(4095, 4095);
    queue_pixel(0, 0);
    queue_pixel(1, 0);
    wait_idle();

    // A limit of zero runs no iteration and reports the pixel as inside.
    write_reg(REG_ORIGIN_RE, '0);
    write_reg(REG_ORIGIN_IM, '0);
    write_reg(REG_STEP, '0);
    write_reg(REG_MAX_ITER, '0);
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    wait_idle();

    // A limit of one: inside, immediate escape, and a point reported inside although its next iterate escapes.
    write_reg(REG_STEP, 32'h1000_0000);
    write_reg(REG_MAX_ITER, 32'd1);
    queue_pixel(0, 0);
    queue_pixel(3, 0);
    queue_pixel(1, 1);
    wait_idle();

    // Largest limit: one full-length pixel plus two quick escapes.
    write_reg(REG_STEP, 32'(STEP_RESET));
    write_reg(REG_MAX_ITER, 32'hFFFF);
    queue_pixel(0, 0);
    queue_pixel(300, 0);
    queue_pixel(150, 150);
    wait_idle();

    for (int i = 0; i < RANDOM_PHASES; i++) begin
      run_random_phase(i);
    end

    if (bad_beats == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
